// ----- hw/rtl/avacc_pkg.sv -----
package avacc_pkg;

	// Width of every running sum and of the weighted totals.
	localparam int ACC_W = 64;
	// Adder width that holds any sum plus the widest per-node term.
	localparam int ADD_W = 67;
	// Node groups and quantities per group.
	localparam int NUM_GROUPS = 2;
	localparam int NUM_QTY    = 4;
	localparam int CFG_IDX_W  = 3;

	// Quantity slots: moment of inertia, then angular momentum x, y, z.
	localparam logic [1:0] QTY_INERTIA = 2'd0;
	localparam logic [1:0] QTY_MOM_Z   = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MEMBRANE_MASS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIN_MASS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE_POS_X  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE_POS_Y  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE_POS_Z  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE_VEL_X  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE_VEL_Y  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE_VEL_Z  = 3'd7;

	localparam logic [31:0] MASS_RESET = 32'h0001_0000;

	// Closed set of sums: [group][quantity], group 0 membrane, group 1 actin.
	typedef logic [NUM_GROUPS-1:0][NUM_QTY-1:0][ACC_W-1:0] sums_t;

	// Clamp a wide signed value to the signed 64-bit range.
	function automatic logic [ACC_W-1:0] sat64(input logic signed [ADD_W-1:0] x);
		logic [ADD_W-ACC_W:0] top;
		top = x[ADD_W-1:ACC_W-1];
		if ((top == '0) || (top == '1)) begin
			sat64 = x[ACC_W-1:0];
		end else if (x[ADD_W-1]) begin
			sat64 = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			sat64 = {1'b0, {(ACC_W-1){1'b1}}};
		end
	endfunction

endpackage

// ----- hw/rtl/avacc_front.sv -----
module avacc_front #(
	parameter int FRAC_BITS   = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 node_group,
	input  logic [31:0]          pos_x,
	input  logic [31:0]          pos_y,
	input  logic [31:0]          pos_z,
	input  logic [31:0]          vel_x,
	input  logic [31:0]          vel_y,
	input  logic [31:0]          vel_z,
	input  logic                 last_node,
	input  logic [31:0]          cpos_x,
	input  logic [31:0]          cpos_y,
	input  logic [31:0]          cpos_z,
	input  logic [31:0]          cvel_x,
	input  logic [31:0]          cvel_y,
	input  logic [31:0]          cvel_z,
	input  logic                 q_full,
	output logic                 q_push,
	output avacc_pkg::sums_t     q_data
);
	import avacc_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int PW = 2 * CW;
	localparam int SW = 2 * CW + 2;

	function automatic logic signed [CW-1:0] rel(input logic [31:0] a, input logic [31:0] b);
		logic signed [CW:0] d;
		d = $signed({a[CW-1], a[CW-1:0]}) - $signed({b[CW-1], b[CW-1:0]});
		if (d[CW] != d[CW-1]) begin
			rel = d[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		end else begin
			rel = d[CW-1:0];
		end
	endfunction

	logic adv;
	logic vld_s1, vld_s2, vld_s3;
	logic grp_s1, grp_s2, grp_s3;
	logic last_s1, last_s2, last_s3;
	logic signed [CW-1:0] px_s1, py_s1, pz_s1, vx_s1, vy_s1, vz_s1;
	logic signed [PW-1:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx, p_xx, p_yy, p_zz;
	logic signed [PW-1:0] m_yz_s2, m_zy_s2, m_zx_s2, m_xz_s2, m_xy_s2, m_yx_s2;
	logic signed [PW-1:0] sq_x_s2, sq_y_s2, sq_z_s2;
	logic signed [SW-1:0] inc_s3 [NUM_QTY];
	sums_t sum_q, sum_nx;

	// Hold the whole pipe while a closing node waits for a queue slot.
	assign full = vld_s3 && last_s3 && q_full;
	assign adv  = !full;

	assign p_yz = py_s1 * vz_s1;
	assign p_zy = pz_s1 * vy_s1;
	assign p_zx = pz_s1 * vx_s1;
	assign p_xz = px_s1 * vz_s1;
	assign p_xy = px_s1 * vy_s1;
	assign p_yx = py_s1 * vx_s1;
	assign p_xx = px_s1 * px_s1;
	assign p_yy = py_s1 * py_s1;
	assign p_zz = pz_s1 * pz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= push;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			grp_s1  <= node_group;
			last_s1 <= last_node;
			px_s1   <= rel(pos_x, cpos_x);
			py_s1   <= rel(pos_y, cpos_y);
			pz_s1   <= rel(pos_z, cpos_z);
			vx_s1   <= rel(vel_x, cvel_x);
			vy_s1   <= rel(vel_y, cvel_y);
			vz_s1   <= rel(vel_z, cvel_z);

			grp_s2  <= grp_s1;
			last_s2 <= last_s1;
			m_yz_s2 <= p_yz >>> FRAC_BITS;
			m_zy_s2 <= p_zy >>> FRAC_BITS;
			m_zx_s2 <= p_zx >>> FRAC_BITS;
			m_xz_s2 <= p_xz >>> FRAC_BITS;
			m_xy_s2 <= p_xy >>> FRAC_BITS;
			m_yx_s2 <= p_yx >>> FRAC_BITS;
			sq_x_s2 <= p_xx >>> FRAC_BITS;
			sq_y_s2 <= p_yy >>> FRAC_BITS;
			sq_z_s2 <= p_zz >>> FRAC_BITS;

			grp_s3    <= grp_s2;
			last_s3   <= last_s2;
			inc_s3[0] <= SW'(sq_x_s2) + SW'(sq_y_s2) + SW'(sq_z_s2);
			inc_s3[1] <= SW'(m_yz_s2) - SW'(m_zy_s2);
			inc_s3[2] <= SW'(m_zx_s2) - SW'(m_xz_s2);
			inc_s3[3] <= SW'(m_xy_s2) - SW'(m_yx_s2);
		end
	end

	always_comb begin
		sum_nx = sum_q;
		for (int k = 0; k < NUM_QTY; k++) begin
			sum_nx[grp_s3][k] = sat64(ADD_W'($signed(sum_q[grp_s3][k])) + ADD_W'(inc_s3[k]));
		end
	end

	assign q_push = vld_s3 && last_s3 && !q_full;
	assign q_data = sum_nx;

	// Clear the sums once a set closes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (adv && vld_s3) begin
			sum_q <= last_s3 ? '0 : sum_nx;
		end
	end

endmodule

// ----- hw/rtl/avacc_queue.sv -----
module avacc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  avacc_pkg::sums_t  wr_data,
	output logic              q_full,
	input  logic              rd_en,
	output logic              q_empty,
	output avacc_pkg::sums_t  rd_data
);
	import avacc_pkg::*;

	sums_t      ent_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign q_full  = (cnt_q == 2'd2);
	assign q_empty = (cnt_q == 2'd0);
	assign rd_data = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en) wr_ptr_q <= !wr_ptr_q;
			if (rd_en) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) ent_q[wr_ptr_q] <= wr_data;
	end

endmodule

// ----- hw/rtl/avacc_back.sv -----
module avacc_back #(
	parameter int FRAC_BITS   = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  avacc_pkg::sums_t  head,
	output logic              q_pop,
	input  logic [31:0]       membrane_mass,
	input  logic [31:0]       actin_mass,
	output logic              empty,
	input  logic              pop,
	output logic [31:0]       omega_x,
	output logic [31:0]       omega_y,
	output logic [31:0]       omega_z,
	output logic              zero_inertia
);
	import avacc_pkg::*;

	localparam int CW    = COORD_WIDTH;
	localparam int DW    = ACC_W + FRAC_BITS;
	localparam int CNT_W = $clog2(DW);

	typedef enum logic [10:0] {
		ST_IDLE    = 11'b000_0000_0001,
		ST_MAG     = 11'b000_0000_0010,
		ST_MUL_HI  = 11'b000_0000_0100,
		ST_MUL_LO  = 11'b000_0000_1000,
		ST_SUM     = 11'b000_0001_0000,
		ST_ACC     = 11'b000_0010_0000,
		ST_QDONE   = 11'b000_0100_0000,
		ST_DIV     = 11'b000_1000_0000,
		ST_DIV_FIN = 11'b001_0000_0000,
		ST_NEXT    = 11'b010_0000_0000,
		ST_OUT     = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	logic [1:0] k_q;
	logic       g_q;
	logic       neg_q;
	logic [ACC_W-1:0] mag_q, acc_q, inertia_q, a_q, b_q, rem_q;
	logic [95:0] full_q;
	logic [DW-1:0] dvd_q;
	logic [CW-1:0] quo_q;
	logic          ovf_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [CW-1:0] omega_q [3];
	logic out_vld_q;

	logic [31:0] mass;
	logic [ACC_W-1:0] sel;
	logic [95:0] shr, lim96, rmag;
	logic [ACC_W-1:0] wgt;
	logic [ACC_W:0] trial;
	logic qbit;
	logic [ACC_W-1:0] rem_nx;
	logic [CW-1:0] limv, res;
	logic [1:0] oidx;

	assign mass  = g_q ? actin_mass : membrane_mass;
	assign sel   = head[g_q][k_q];
	assign shr   = full_q >> FRAC_BITS;
	assign lim96 = neg_q ? {32'd0, 1'b1, 63'd0} : {32'd0, 1'b0, {63{1'b1}}};
	assign rmag  = (shr > lim96) ? lim96 : shr;
	assign wgt   = neg_q ? (ACC_W'(0) - rmag[ACC_W-1:0]) : rmag[ACC_W-1:0];

	// One restoring-division step per cycle.
	assign trial  = {rem_q, dvd_q[DW-1]};
	assign qbit   = (trial >= {1'b0, inertia_q});
	assign rem_nx = qbit ? ACC_W'(trial - {1'b0, inertia_q}) : trial[ACC_W-1:0];

	assign limv = neg_q ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
	assign res  = (ovf_q || (quo_q > limv)) ? limv : quo_q;
	assign oidx = k_q - 2'd1;

	assign q_pop = (state_q == ST_OUT) && !out_vld_q;
	assign empty = !out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			k_q       <= QTY_INERTIA;
			g_q       <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (pop && out_vld_q) out_vld_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						k_q     <= QTY_INERTIA;
						g_q     <= 1'b0;
						state_q <= ST_MAG;
					end
				end
				ST_MAG:    state_q <= ST_MUL_HI;
				ST_MUL_HI: state_q <= ST_MUL_LO;
				ST_MUL_LO: state_q <= ST_SUM;
				ST_SUM:    state_q <= ST_ACC;
				ST_ACC: begin
					if (!g_q) begin
						g_q     <= 1'b1;
						state_q <= ST_MAG;
					end else begin
						state_q <= ST_QDONE;
					end
				end
				ST_QDONE: begin
					if (k_q == QTY_INERTIA) begin
						k_q     <= k_q + 2'd1;
						g_q     <= 1'b0;
						state_q <= ST_MAG;
					end else if ($signed(inertia_q) <= 0) begin
						state_q <= ST_NEXT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(DW - 1)) state_q <= ST_DIV_FIN;
				end
				ST_DIV_FIN: state_q <= ST_NEXT;
				ST_NEXT: begin
					if (k_q == QTY_MOM_Z) begin
						state_q <= ST_OUT;
					end else begin
						k_q     <= k_q + 2'd1;
						g_q     <= 1'b0;
						state_q <= ST_MAG;
					end
				end
				ST_OUT: begin
					if (!out_vld_q) begin
						out_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: acc_q <= '0;
			ST_MAG: begin
				neg_q <= sel[ACC_W-1];
				mag_q <= sel[ACC_W-1] ? (ACC_W'(0) - sel) : sel;
			end
			ST_MUL_HI: a_q <= mag_q[63:32] * mass;
			ST_MUL_LO: b_q <= mag_q[31:0] * mass;
			ST_SUM:    full_q <= {a_q, 32'd0} + {32'd0, b_q};
			ST_ACC:    acc_q <= sat64(ADD_W'($signed(acc_q)) + ADD_W'($signed(wgt)));
			ST_QDONE: begin
				if (k_q == QTY_INERTIA) begin
					inertia_q <= acc_q;
					acc_q     <= '0;
				end else begin
					neg_q <= acc_q[ACC_W-1];
					dvd_q <= {(acc_q[ACC_W-1] ? (ACC_W'(0) - acc_q) : acc_q),
						{FRAC_BITS{1'b0}}};
					rem_q <= '0;
					quo_q <= '0;
					ovf_q <= 1'b0;
					cnt_q <= '0;
					omega_q[oidx] <= '0;
				end
			end
			ST_DIV: begin
				dvd_q <= dvd_q << 1;
				rem_q <= rem_nx;
				quo_q <= {quo_q[CW-2:0], qbit};
				ovf_q <= ovf_q | quo_q[CW-1];
				cnt_q <= cnt_q + CNT_W'(1);
			end
			ST_DIV_FIN: omega_q[oidx] <= neg_q ? (CW'(0) - res) : res;
			ST_NEXT:    acc_q <= '0;
			ST_OUT: begin
				if (!out_vld_q) begin
					omega_x      <= 32'(omega_q[0]);
					omega_y      <= 32'(omega_q[1]);
					omega_z      <= 32'(omega_q[2]);
					zero_inertia <= ($signed(inertia_q) <= 0);
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- hw/rtl/angular_velocity_accumulator.sv -----
// Flow: a node passes the front's s1, s2 and s3 registers before it reaches the running
// sums; the finalize unit weighs a closed set by mass and divides each momentum sum by
// the inertia (skipped when inertia is zero or negative) before its result shows.
// Throughput: one node per cycle unless full holds the pipe; the bit-serial divider
// sets how often sets close; the queue holds the set in work plus one more closed set.
// Reset: arst_n clears sums, queue and result-valid flag; masses read 1.0, centre terms 0.
module angular_velocity_accumulator #(
	parameter int FRAC_BITS   = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// node transactions
	input  logic        push,
	output logic        full,
	input  logic        node_group,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [31:0] pos_z,
	input  logic [31:0] vel_x,
	input  logic [31:0] vel_y,
	input  logic [31:0] vel_z,
	input  logic        last_node,
	// result transactions
	output logic        empty,
	input  logic        pop,
	output logic [31:0] omega_x,
	output logic [31:0] omega_y,
	output logic [31:0] omega_z,
	output logic        zero_inertia,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [avacc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data
);
	import avacc_pkg::*;

	logic [31:0] membrane_mass_q, actin_mass_q;
	logic [31:0] cpos_x_q, cpos_y_q, cpos_z_q;
	logic [31:0] cvel_x_q, cvel_y_q, cvel_z_q;

	logic  q_full, q_push, q_empty, q_pop;
	sums_t q_wdata, q_rdata;

	// Configuration writes are always taken; issue them only while no node is in flight.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			membrane_mass_q <= MASS_RESET;
			actin_mass_q    <= MASS_RESET;
			cpos_x_q        <= '0;
			cpos_y_q        <= '0;
			cpos_z_q        <= '0;
			cvel_x_q        <= '0;
			cvel_y_q        <= '0;
			cvel_z_q        <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MEMBRANE_MASS: membrane_mass_q <= cfg_data;
				REG_ACTIN_MASS:    actin_mass_q    <= cfg_data;
				REG_CENTRE_POS_X:  cpos_x_q        <= cfg_data;
				REG_CENTRE_POS_Y:  cpos_y_q        <= cfg_data;
				REG_CENTRE_POS_Z:  cpos_z_q        <= cfg_data;
				REG_CENTRE_VEL_X:  cvel_x_q        <= cfg_data;
				REG_CENTRE_VEL_Y:  cvel_y_q        <= cfg_data;
				REG_CENTRE_VEL_Z:  cvel_z_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front: subtract centre, form cross product and squared radius, accumulate
	// per group; a closing node hands its set of sums to the queue.
	avacc_front #(
		.FRAC_BITS   (FRAC_BITS),
		.COORD_WIDTH (COORD_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.node_group (node_group),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.vel_x      (vel_x),
		.vel_y      (vel_y),
		.vel_z      (vel_z),
		.last_node  (last_node),
		.cpos_x     (cpos_x_q),
		.cpos_y     (cpos_y_q),
		.cpos_z     (cpos_z_q),
		.cvel_x     (cvel_x_q),
		.cvel_y     (cvel_y_q),
		.cvel_z     (cvel_z_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_wdata)
	);

	// Two closed sets fit here; the head stays until the finalize unit is done with it.
	avacc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wdata),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.q_empty (q_empty),
		.rd_data (q_rdata)
	);

	// Back: weigh sums by mass, divide momentum by inertia, hold the result.
	avacc_back #(
		.FRAC_BITS   (FRAC_BITS),
		.COORD_WIDTH (COORD_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.head          (q_rdata),
		.q_pop         (q_pop),
		.membrane_mass (membrane_mass_q),
		.actin_mass    (actin_mass_q),
		.empty         (empty),
		.pop           (pop),
		.omega_x       (omega_x),
		.omega_y       (omega_y),
		.omega_z       (omega_z),
		.zero_inertia  (zero_inertia)
	);

endmodule
